/* rtl/sfdn_pkg.sv */
// Package for the stereo FDN reverb: widths, line lengths, register indexes.
// No dependencies.
`timescale 1ns / 1ps
package sfdn_pkg;
  localparam int LINES_DEF = 8;
  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int COEF_WIDTH_DEF = 16;
  localparam int STORE_DEPTH_DEF = 23038;
  localparam int GAIN_FRAC = 14;
  localparam int GAIN_WIDTH = 16;
  localparam int CFG_IDX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH = 64;
  localparam int PTR_WIDTH = 13;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_DAMP_LOW   = 3'd0,
    REG_DAMP_HIGH  = 3'd1,
    REG_ATTEN_LOW  = 3'd2,
    REG_ATTEN_HIGH = 3'd3,
    REG_DRY        = 3'd4,
    REG_WET_NARROW = 3'd5,
    REG_WET_WIDE   = 3'd6,
    REG_UNUSED     = 3'd7
  } reg_idx_t;

  function automatic logic [PTR_WIDTH-1:0] line_len(input logic [2:0] i);
    logic [PTR_WIDTH-1:0] r;
    case (i)
      3'd0: r = 13'd439;
      3'd1: r = 13'd997;
      3'd2: r = 13'd1601;
      3'd3: r = 13'd2251;
      3'd4: r = 13'd2897;
      3'd5: r = 13'd3583;
      3'd6: r = 13'd4271;
      default: r = 13'd4999;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] line_base(input logic [2:0] i);
    logic [15:0] r;
    case (i)
      3'd0: r = 16'd0;
      3'd1: r = 16'd439;
      3'd2: r = 16'd1436;
      3'd3: r = 16'd3037;
      3'd4: r = 16'd5288;
      3'd5: r = 16'd8185;
      3'd6: r = 16'd11768;
      default: r = 16'd16039;
    endcase
    return r;
  endfunction
endpackage

/* rtl/sfdn_if.sv */
// Valid/ready stream and config write interfaces.
// Depends on sfdn_pkg.
`timescale 1ns / 1ps
interface sfdn_stream_if #(parameter int W = 24);
  logic valid;
  logic ready;
  logic signed [W-1:0] left;
  logic signed [W-1:0] right;
  modport source (output valid, left, right, input ready);
  modport sink (input valid, left, right, output ready);
endinterface

interface sfdn_cfg_if;
  logic valid;
  logic ready;
  logic [sfdn_pkg::CFG_IDX_WIDTH-1:0] index;
  logic [sfdn_pkg::CFG_DATA_WIDTH-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/sfdn_store.sv */
// One delay store: synchronous RAM, one write and one registered read port.
// Depends on sfdn_pkg.
`timescale 1ns / 1ps
module sfdn_store #(
  parameter int DEPTH = sfdn_pkg::STORE_DEPTH_DEF,
  parameter int W = 28
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic signed [W-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic signed [W-1:0] rdata
);
  logic signed [W-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* rtl/stereo_fdn_reverb.sv */
// Stereo FDN reverb, top level: sequencer, damping filters, output mix.
// Depends on sfdn_pkg, sfdn_if, sfdn_store.
//
// Usage: samples enter on in_ch (left/right pair per beat), results leave on
// out_ch, coefficients are written on cfg_ch (index per register list).
// After reset the block first clears all STORE_DEPTH words of both stores
// (23038 by default), one word per cycle; no input is taken meanwhile, config
// writes are. An item then runs a read pass per line (one store read, four
// multiplies on the shared multiplier), a write-back pass over the lines, the
// mix of dry and wet products and the load of the output register. A new item
// is taken only once the previous one has reached the output register. The
// output register frees the core, so the next item is taken while a result
// waits. If the receiver stalls, the next finished result is held in the
// core and no further item is accepted until out_ch takes its beat.
`timescale 1ns / 1ps
module stereo_fdn_reverb #(
  parameter int SAMPLE_WIDTH = sfdn_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH = sfdn_pkg::COEF_WIDTH_DEF,
  parameter int STORE_DEPTH = sfdn_pkg::STORE_DEPTH_DEF
) (
  input logic clk,
  input logic rst,
  sfdn_stream_if.sink in_ch,
  sfdn_stream_if.source out_ch,
  sfdn_cfg_if.sink cfg_ch
);
  import sfdn_pkg::*;

  localparam int LINES = LINES_DEF;
  localparam int SW = SAMPLE_WIDTH + 4;
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int LW = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int FRAC = COEF_WIDTH - 1;
  localparam int PW = SW + COEF_WIDTH + 1;
  localparam int MW = SW + GAIN_WIDTH + 4;

  // start word of each line, wrapped into the store
  localparam logic [AW-1:0] BASE_MOD [8] = '{
    AW'(int'(line_base(3'd0)) % STORE_DEPTH), AW'(int'(line_base(3'd1)) % STORE_DEPTH),
    AW'(int'(line_base(3'd2)) % STORE_DEPTH), AW'(int'(line_base(3'd3)) % STORE_DEPTH),
    AW'(int'(line_base(3'd4)) % STORE_DEPTH), AW'(int'(line_base(3'd5)) % STORE_DEPTH),
    AW'(int'(line_base(3'd6)) % STORE_DEPTH), AW'(int'(line_base(3'd7)) % STORE_DEPTH)
  };

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001, S_IDLE = 7'b0000010, S_READ = 7'b0000100,
    S_FILT = 7'b0001000, S_WRITE = 7'b0010000, S_MIX = 7'b0100000,
    S_OUT = 7'b1000000
  } state_t;

  state_t state;
  logic [63:0] damp_lo, damp_hi, atten_lo, atten_hi;
  logic [GAIN_WIDTH-1:0] dry, wet_n, wet_w;
  logic [PTR_WIDTH-1:0] ptr [LINES];
  logic signed [SW-1:0] st_r [LINES];
  logic signed [SW-1:0] st_l [LINES];
  logic [AW-1:0] addr [LINES];
  logic [AW:0] clr_cnt;
  logic [LW:0] line;
  logic [2:0] phase;
  logic signed [SAMPLE_WIDTH-1:0] lin, rin;
  logic signed [SW+3:0] sum_r, sum_l;
  logic signed [SW-1:0] avg_r, avg_l;
  logic signed [MW-1:0] acc_l, acc_r;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      damp_lo <= '0; damp_hi <= '0; atten_lo <= '0; atten_hi <= '0;
      dry <= 16'd16384; wet_n <= '0; wet_w <= '0;
    end else if (cfg_ch.valid) begin
      case (reg_idx_t'(cfg_ch.index))
        REG_DAMP_LOW: damp_lo <= cfg_ch.data;
        REG_DAMP_HIGH: damp_hi <= cfg_ch.data;
        REG_ATTEN_LOW: atten_lo <= cfg_ch.data;
        REG_ATTEN_HIGH: atten_hi <= cfg_ch.data;
        REG_DRY: dry <= cfg_ch.data[GAIN_WIDTH-1:0];
        REG_WET_NARROW: wet_n <= cfg_ch.data[GAIN_WIDTH-1:0];
        REG_WET_WIDE: wet_w <= cfg_ch.data[GAIN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic signed [COEF_WIDTH-1:0] coef(input logic [63:0] lo,
      input logic [63:0] hi, input logic [2:0] i);
    logic [127:0] r;
    r = {64'd0, (i[2] ? hi : lo)} >> (COEF_WIDTH * int'(i[1:0]));
    return r[COEF_WIDTH-1:0];
  endfunction

  function automatic logic signed [SW-1:0] sat_sw(input logic signed [PW+1:0] v);
    logic signed [PW+1:0] hi, lo;
    hi = ((PW+2)'(1) <<< (SW-1)) - (PW+2)'(1);
    lo = -hi - 1;
    return (v > hi) ? hi[SW-1:0] : ((v < lo) ? lo[SW-1:0] : v[SW-1:0]);
  endfunction

  // line index, mem read/write
  logic [2:0] li;
  assign li = 3'(line);
  logic [LW-1:0] lx;
  assign lx = line[LW-1:0];
  logic [AW-1:0] cur_addr;
  assign cur_addr = addr[lx];

  assign avg_r = SW'(sum_r >>> LW);
  assign avg_l = SW'(sum_l >>> LW);

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic signed [SW-1:0] wd_l, wd_r, rd_l, rd_r;
  always_comb begin
    we = 1'b0; waddr = addr[lx]; wd_l = '0; wd_r = '0;
    if (state == S_CLEAR) begin
      we = 1'b1; waddr = clr_cnt[AW-1:0];
    end else if (state == S_WRITE) begin
      we = 1'b1;
      wd_l = sat_sw((PW+2)'(avg_r) - (PW+2)'(st_r[lx]) + (PW+2)'(lin));
      wd_r = sat_sw((PW+2)'(avg_l) - (PW+2)'(st_l[lx]) + (PW+2)'(rin));
    end
    raddr = cur_addr;
  end

  sfdn_store #(.DEPTH(STORE_DEPTH), .W(SW)) u_left (
    .clk, .we, .waddr, .wdata(wd_l), .raddr, .rdata(rd_l));
  sfdn_store #(.DEPTH(STORE_DEPTH), .W(SW)) u_right (
    .clk, .we, .waddr, .wdata(wd_r), .raddr, .rdata(rd_r));

  // shared multiplier, registered
  logic signed [SW-1:0] ma;
  logic signed [COEF_WIDTH:0] mb;
  logic signed [PW-1:0] prod;
  logic signed [PW+1:0] facc;
  always_comb begin
    case (phase)
      3'd0: begin ma = st_r[lx]; mb = (COEF_WIDTH+1)'(coef(damp_lo, damp_hi, li)); end
      3'd1: begin ma = rd_r; mb = (COEF_WIDTH+1)'(coef(atten_lo, atten_hi, li)); end
      3'd2: begin ma = st_l[lx]; mb = (COEF_WIDTH+1)'(coef(damp_lo, damp_hi, li)); end
      3'd3: begin ma = rd_l; mb = (COEF_WIDTH+1)'(coef(atten_lo, atten_hi, li)); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  logic signed [MW-1:0] gprod;
  logic signed [SW-1:0] ga;
  logic [GAIN_WIDTH-1:0] gb;
  always_comb begin
    case (phase)
      3'd0: begin ga = avg_r; gb = wet_n; end
      3'd1: begin ga = avg_l; gb = wet_w; end
      3'd2: begin ga = SW'(lin); gb = dry; end
      3'd3: begin ga = avg_r; gb = wet_w; end
      3'd4: begin ga = avg_l; gb = wet_n; end
      default: begin ga = SW'(rin); gb = dry; end
    endcase
  end

  function automatic logic signed [SAMPLE_WIDTH-1:0] sat_out(input logic signed [MW-1:0] v);
    logic signed [MW-1:0] r, hi, lo;
    r = (v + MW'(2 ** (GAIN_FRAC-1))) >>> GAIN_FRAC;
    hi = (MW'(1) <<< (SAMPLE_WIDTH-1)) - MW'(1);
    lo = -hi - 1;
    return (r > hi) ? hi[SAMPLE_WIDTH-1:0] : ((r < lo) ? lo[SAMPLE_WIDTH-1:0]
        : r[SAMPLE_WIDTH-1:0]);
  endfunction

  logic signed [PW+1:0] rnd;
  assign rnd = (facc + prod + (PW+2)'(2 ** (FRAC-1))) >>> FRAC;

  assign in_ch.ready = (state == S_IDLE);

  // output register: loads a finished result when empty or when its beat leaves this cycle
  logic out_load;
  assign out_load = (state == S_OUT) && (!out_ch.valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_load) begin
      out_ch.left <= sat_out(acc_l);
      out_ch.right <= sat_out(acc_r + gprod);
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; clr_cnt <= '0;
      line <= '0; phase <= '0;
      for (int i = 0; i < LINES; i++) begin
        ptr[i] <= '0; st_r[i] <= '0; st_l[i] <= '0; addr[i] <= BASE_MOD[i];
      end
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (AW+1)'(STORE_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: if (in_ch.valid) begin
          lin <= in_ch.left; rin <= in_ch.right;
          line <= '0; sum_r <= '0; sum_l <= '0; state <= S_READ;
        end
        S_READ: begin
          phase <= '0; state <= S_FILT;
        end
        S_FILT: begin
          prod <= ma * mb;
          phase <= phase + 1'b1;
          case (phase)
            3'd0: facc <= '0;
            3'd1: facc <= (PW+2)'(prod);
            3'd2: begin
              st_r[lx] <= sat_sw(rnd);
              sum_r <= sum_r + (SW+4)'(sat_sw(rnd));
            end
            3'd3: facc <= (PW+2)'(prod);
            default: begin
              st_l[lx] <= sat_sw(rnd);
              sum_l <= sum_l + (SW+4)'(sat_sw(rnd));
              if (line == (LW+1)'(LINES - 1)) begin
                line <= '0; state <= S_WRITE;
              end else begin
                line <= line + 1'b1; state <= S_READ;
              end
            end
          endcase
        end
        S_WRITE: begin
          if (ptr[lx] + 1'b1 >= line_len(li)) begin
            ptr[lx] <= '0;
            addr[lx] <= BASE_MOD[lx];
          end else begin
            ptr[lx] <= ptr[lx] + 1'b1;
            if ((AW+1)'(addr[lx]) + 1'b1 == (AW+1)'(STORE_DEPTH)) addr[lx] <= '0;
            else addr[lx] <= addr[lx] + 1'b1;
          end
          if (line == (LW+1)'(LINES - 1)) begin
            phase <= '0; state <= S_MIX;
          end else line <= line + 1'b1;
        end
        S_MIX: begin
          gprod <= ga * $signed({1'b0, gb});
          phase <= phase + 1'b1;
          case (phase)
            3'd0: acc_l <= '0;
            3'd1, 3'd2: acc_l <= acc_l + gprod;
            3'd3: begin acc_l <= acc_l + gprod; acc_r <= '0; end
            3'd4, 3'd5: acc_r <= acc_r + gprod;
            default: state <= S_OUT;
          endcase
        end
        S_OUT: if (out_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
